>>> sv/ctgr_pkg.sv
package ctgr_pkg;

  localparam int ROM_LEN       = 20;
  localparam int MAX_RAMP_SIZE = 4096;
  localparam int DIV_STAGES    = 8;   // two quotient bits per stage
  localparam int NUM_STAGES    = 6 + DIV_STAGES;

  localparam logic [13:0] TEMP_DEFAULT = 14'd6500;
  localparam logic [13:0] TEMP_LOW     = 14'd1000;
  localparam logic [13:0] TEMP_HIGH    = 14'd10000;
  localparam logic [8:0]  TEMP_STEP    = 9'd500;
  localparam logic [4:0]  STEP_MAX     = 5'd18;
  localparam logic [12:0] SIZE_MAX     = 13'd4096;

  // floor(t/500) = (t * 33555) >> 24 for t up to 9000
  localparam logic [15:0] STEP_RECIP   = 16'd33555;
  // floor(x/500) = (x * 34359739) >> 34 for x below 2^25
  localparam logic [25:0] GAIN_RECIP   = 26'd34359739;

  localparam logic CFG_COLOR_TEMP = 1'b0;
  localparam logic CFG_RAMP_SIZE  = 1'b1;

  typedef logic [16:0] gain_t;

  localparam gain_t ROM_RED [ROM_LEN] = '{
    17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
    17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd62365, 17'd59765,
    17'd57610, 17'd55797, 17'd54253, 17'd52922, 17'd51766, 17'd50753};
  localparam gain_t ROM_GREEN [ROM_LEN] = '{
    17'd11910, 17'd27737, 17'd35625, 17'd42188, 17'd47171, 17'd51110, 17'd54300,
    17'd56925, 17'd59112, 17'd61508, 17'd63640, 17'd65536, 17'd63559, 17'd61912,
    17'd60527, 17'd59349, 17'd58335, 17'd57454, 17'd56683, 17'd56003};
  localparam gain_t ROM_BLUE [ROM_LEN] = '{
    17'd0,     17'd0,     17'd5688,  17'd18887, 17'd28089, 17'd35810, 17'd42478,
    17'd48293, 17'd53389, 17'd57757, 17'd61804, 17'd65536, 17'd65536, 17'd65536,
    17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536};

  function automatic gain_t rom_gain(input logic [1:0] ch, input logic [4:0] idx);
    gain_t g;
    g = '0;
    case (ch)
      2'd0: g = ROM_RED[idx];
      2'd1: g = ROM_GREEN[idx];
      2'd2: g = ROM_BLUE[idx];
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

>>> sv/color_temperature_gamma_ramp.sv
// Channel  Handshake            Payload
// cfg      cfg_valid/cfg_ready  cfg_index (0 temp, 1 size), cfg_data[13:0]
// in       in_valid/in_ready    in_ramp_index[11:0]
// out      out_valid/out_ready  out_red_level, out_green_level, out_blue_level
//
// One item per clock sustained while out_ready is high; 6 gain/product stages,
// then 8 divider stages resolving two quotient bits each against ramp_size.
// Synchronous active-low reset clears the valid bits and restores the
// registers to 6500 K and a 256-entry ramp. A stall at the output backs up
// stage by stage; empty stages keep filling, so no transfer is lost or doubled.
module color_temperature_gamma_ramp
  import ctgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_ramp_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red_level,
  output logic [15:0] out_green_level,
  output logic [15:0] out_blue_level
);

  logic [13:0] color_temp_r;
  logic [12:0] ramp_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_temp_r <= TEMP_DEFAULT;
      ramp_size_r  <= 13'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLOR_TEMP: color_temp_r <= cfg_data;
        CFG_RAMP_SIZE:  ramp_size_r  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage advance: a stage moves when empty or when the
  // stage after it moves.
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: replace an out-of-range temperature with the default, clamp the size, find the table step.
  logic [13:0] temp_sel;
  logic [13:0] t_nxt;
  logic [29:0] step_prod;
  logic [4:0]  step_nxt;
  logic [12:0] size_nxt;

  always_comb begin
    temp_sel  = (color_temp_r < TEMP_LOW || color_temp_r > TEMP_HIGH) ?
                TEMP_DEFAULT : color_temp_r;
    t_nxt     = temp_sel - TEMP_LOW;
    step_prod = 30'(t_nxt) * 30'(STEP_RECIP);
    step_nxt  = (step_prod[29:24] > 6'(STEP_MAX)) ? STEP_MAX : step_prod[28:24];
    if (ramp_size_r == 13'd0) size_nxt = 13'd1;
    else if (ramp_size_r > SIZE_MAX) size_nxt = SIZE_MAX;
    else size_nxt = ramp_size_r;
  end

  logic [11:0] idx1_r;
  logic [13:0] t1_r;
  logic [4:0]  step1_r;
  logic [12:0] size1_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      idx1_r  <= in_ramp_index;
      t1_r    <= t_nxt;
      step1_r <= step_nxt;
      size1_r <= size_nxt;
    end
  end

  // Stage 2: remainder within the step, fetch the two bracketing entries.
  logic [13:0] rem_full;
  always_comb begin
    rem_full = t1_r - 14'(step1_r) * 14'(TEMP_STEP);
  end

  logic [11:0] idx2_r;
  logic [12:0] size2_r;
  logic [8:0]  rem2_r;
  gain_t       g0_r [3];
  gain_t       g1_r [3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      idx2_r  <= idx1_r;
      size2_r <= size1_r;
      rem2_r  <= rem_full[8:0];
      for (int c = 0; c < 3; c++) begin
        g0_r[c] <= rom_gain(2'(c), step1_r);
        g1_r[c] <= rom_gain(2'(c), step1_r + 5'd1);
      end
    end
  end

  // Stage 3: weighted sum of the two entries.
  logic [11:0] idx3_r;
  logic [12:0] size3_r;
  logic [25:0] sum3_r [3];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      idx3_r  <= idx2_r;
      size3_r <= size2_r;
      for (int c = 0; c < 3; c++) begin
        sum3_r[c] <= 26'(g0_r[c]) * 26'(TEMP_STEP - rem2_r) +
                     26'(g1_r[c]) * 26'(rem2_r);
      end
    end
  end

  // Stage 4: divide the sum by the step width through a reciprocal.
  logic [51:0] gprod [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      gprod[c] = 52'(sum3_r[c]) * 52'(GAIN_RECIP);
    end
  end

  logic [11:0] idx4_r;
  logic [12:0] size4_r;
  gain_t       gain4_r [3];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      idx4_r  <= idx3_r;
      size4_r <= size3_r;
      for (int c = 0; c < 3; c++) begin
        gain4_r[c] <= gprod[c][50:34];
      end
    end
  end

  // Stage 5: index times gain.
  logic [12:0] size5_r;
  logic [28:0] p5_r [3];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      size5_r <= size4_r;
      for (int c = 0; c < 3; c++) begin
        p5_r[c] <= 29'(idx4_r) * 29'(gain4_r[c]);
      end
    end
  end

  // Stage 6: scale by 65535, drop the 16 fraction bits, seed the divider.
  logic [44:0] scaled [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scaled[c] = {p5_r[c], 16'd0} - 45'(p5_r[c]);
    end
  end

  logic [12:0] dsize_r [DIV_STAGES+1];
  logic [12:0] drem_r  [DIV_STAGES+1][3];
  logic [15:0] dlow_r  [DIV_STAGES+1][3];
  logic [15:0] dq_r    [DIV_STAGES+1][3];
  logic        dovf_r  [DIV_STAGES+1][3];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      dsize_r[0] <= size5_r;
      for (int c = 0; c < 3; c++) begin
        drem_r[0][c] <= scaled[c][44:32];
        dlow_r[0][c] <= scaled[c][31:16];
        dq_r[0][c]   <= '0;
        // quotient saturates once the high part reaches the divisor
        dovf_r[0][c] <= scaled[c][44:32] >= size5_r;
      end
    end
  end

  // Stages 7..14: restoring division, two quotient bits per stage.
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [13:0] r_a [3];
    logic [13:0] r_b [3];
    logic [13:0] r_a2 [3];
    logic [13:0] r_b2 [3];
    logic        b_a [3];
    logic        b_b [3];

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        r_a[c]  = {drem_r[j][c], dlow_r[j][c][15]};
        b_a[c]  = r_a[c] >= 14'(dsize_r[j]);
        r_a2[c] = b_a[c] ? r_a[c] - 14'(dsize_r[j]) : r_a[c];
        r_b[c]  = {r_a2[c][12:0], dlow_r[j][c][14]};
        b_b[c]  = r_b[c] >= 14'(dsize_r[j]);
        r_b2[c] = b_b[c] ? r_b[c] - 14'(dsize_r[j]) : r_b[c];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[6+j]) begin
        dsize_r[j+1] <= dsize_r[j];
        for (int c = 0; c < 3; c++) begin
          drem_r[j+1][c] <= r_b2[c][12:0];
          dlow_r[j+1][c] <= {dlow_r[j][c][13:0], 2'b00};
          dq_r[j+1][c]   <= {dq_r[j][c][13:0], b_a[c], b_b[c]};
          dovf_r[j+1][c] <= dovf_r[j][c];
        end
      end
    end
  end

  assign out_red_level   = dovf_r[DIV_STAGES][0] ? 16'hFFFF : dq_r[DIV_STAGES][0];
  assign out_green_level = dovf_r[DIV_STAGES][1] ? 16'hFFFF : dq_r[DIV_STAGES][1];
  assign out_blue_level  = dovf_r[DIV_STAGES][2] ? 16'hFFFF : dq_r[DIV_STAGES][2];

endmodule
